// ===== sv/i2c_target_address_match_transmit_unit_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef I2C_TARGET_ADDRESS_MATCH_TRANSMIT_UNIT_MACROS_SVH
`define I2C_TARGET_ADDRESS_MATCH_TRANSMIT_UNIT_MACROS_SVH

// Checks an expression at every clock edge outside reset.
`define I2CTAM_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("i2ctam check failed");

// Checks that a condition in one cycle implies a consequence in the next.
`define I2CTAM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("i2ctam check failed");

`endif

// ===== sv/i2ctam_pkg.sv =====
package i2ctam_pkg;

	// Width of the remaining byte counter.
	localparam int LENGTH_BITS = 8;

	localparam int ADDR_W     = 7;
	localparam int BYTE_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [2:0] {
		EV_NONE       = 3'd0,
		EV_MATCH      = 3'd1,
		EV_MISMATCH   = 3'd2,
		EV_BYTE_TAKEN = 3'd3,
		EV_MASTER_ACK = 3'd4,
		EV_COMPLETE   = 3'd5
	} event_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OWN_ADDRESS     = 2'd0,
		REG_TRANSMIT_LENGTH = 2'd1
	} reg_idx_t;

	typedef struct packed {
		logic   sda_release;
		event_t event_res;
		logic   master_ack;
	} result_t;

endpackage

// ===== sv/i2ctam_ifs.sv =====
interface i2ctam_sample_if;
	logic                           valid;
	logic                           ready;
	logic                           scl_level;
	logic                           sda_level;
	logic [i2ctam_pkg::BYTE_W-1:0]  tx_byte;

	modport source (output valid, output scl_level, output sda_level, output tx_byte,
		input ready);
	modport sink (input valid, input scl_level, input sda_level, input tx_byte,
		output ready);
endinterface

interface i2ctam_result_if;
	logic               valid;
	logic               ready;
	logic               sda_release;
	i2ctam_pkg::event_t event_res;
	logic               master_ack;

	modport source (output valid, output sda_release, output event_res, output master_ack,
		input ready);
	modport sink (input valid, input sda_release, input event_res, input master_ack,
		output ready);
endinterface

interface i2ctam_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [i2ctam_pkg::CFG_IDX_W-1:0]  index;
	logic [i2ctam_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/i2c_target_address_match_transmit_unit.sv =====
// I2C target with seven-bit address match that answers any match with a run of bytes.
// The samples channel carries one synchronized SCL/SDA sample per transaction,
// together with the byte the transmit source offers next; that byte is consumed
// only when the result reports "byte taken". Every sample produces exactly one
// result on the results channel: the SDA release level to apply after this
// sample, an event code and, with a master-ack event, the sampled acknowledge.
// The cfg channel writes own_address (index 0) and transmit_length (index 1);
// it is always ready, and other indexes are dropped.
// An accepted sample is registered in the sample register, processed against the
// protocol state and written into the result queue, which shows it as a valid result.
// Throughput: one sample per clock cycle while the queue has room, set by the state
// update between the sample register and the two-entry result queue.
// When the receiver stalls, results collect in the queue; once the queue is full
// the sample register holds and samples ready drops in that same cycle, so
// nothing is lost. Reset puts the protocol state in idle with SDA released,
// clears both registers and empties the sample register and the result queue.
module i2c_target_address_match_transmit_unit (
	input  logic           clk,
	input  logic           arst_n,
	i2ctam_sample_if.sink  samples,
	i2ctam_result_if.source results,
	i2ctam_cfg_if.sink     cfg
);

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_START = 3'd1,
		PH_ADDR  = 3'd2,
		PH_AACK  = 3'd3,
		PH_TX    = 3'd4,
		PH_MACK  = 3'd5
	} phase_t;

	localparam int LB = i2ctam_pkg::LENGTH_BITS;

	// Configuration registers.
	logic [i2ctam_pkg::ADDR_W-1:0] own_address_q;
	logic [7:0]                    transmit_length_q;

	// Sample register.
	logic                          valid_s1;
	logic                          scl_s1;
	logic                          sda_s1;
	logic [i2ctam_pkg::BYTE_W-1:0] tx_byte_s1;

	// Protocol state.
	phase_t       phase_q, phase_d;
	logic [3:0]   bit_count_q, bit_count_d;
	logic [7:0]   shift_q, shift_d;
	logic [LB-1:0] bytes_left_q, bytes_left_d;
	logic         prev_scl_q, prev_sda_q;
	logic         sda_drive_q, sda_drive_d;
	logic         address_hit_q, address_hit_d;

	logic                 rise, fall;
	logic [3:0]           bc_inc;
	i2ctam_pkg::event_t   ev;
	logic                 mack;
	i2ctam_pkg::result_t  res_d;

	// Result queue.
	i2ctam_pkg::result_t q_mem [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       advance, push, pop;

	assign advance = valid_s1 && (cnt_q != 2'd2);
	assign push    = advance;
	assign pop     = results.valid && results.ready;

	assign samples.ready = !valid_s1 || advance;
	assign cfg.ready     = 1'b1;

	assign results.valid       = (cnt_q != 2'd0);
	assign results.sda_release = q_mem[rd_q].sda_release;
	assign results.event_res   = q_mem[rd_q].event_res;
	assign results.master_ack  = q_mem[rd_q].master_ack;

	assign rise   = !prev_scl_q && scl_s1;
	assign fall   = prev_scl_q && !scl_s1;
	assign bc_inc = bit_count_q + 4'd1;

	always_comb begin
		phase_d       = phase_q;
		bit_count_d   = bit_count_q;
		shift_d       = shift_q;
		bytes_left_d  = bytes_left_q;
		sda_drive_d   = sda_drive_q;
		address_hit_d = address_hit_q;
		ev            = i2ctam_pkg::EV_NONE;
		mack          = 1'b0;
		case (phase_q)
			PH_START: begin
				if (fall) begin
					phase_d     = PH_ADDR;
					bit_count_d = '0;
					shift_d     = '0;
				end
			end
			PH_ADDR: begin
				if (rise && !bit_count_q[3]) begin
					shift_d     = {shift_q[6:0], sda_s1};
					bit_count_d = bc_inc;
				end else if (fall && bit_count_q[3]) begin
					address_hit_d = (shift_q[7:1] == own_address_q);
					sda_drive_d   = !address_hit_d;
					bytes_left_d  = LB'(transmit_length_q);
					ev            = address_hit_d ? i2ctam_pkg::EV_MATCH
						: i2ctam_pkg::EV_MISMATCH;
					bit_count_d   = '0;
					phase_d       = PH_AACK;
				end
			end
			PH_AACK: begin
				if (fall) begin
					sda_drive_d = 1'b1;
					if (!address_hit_q) begin
						phase_d = PH_IDLE;
					end else if (bytes_left_q != '0) begin
						shift_d      = tx_byte_s1;
						sda_drive_d  = tx_byte_s1[7];
						bit_count_d  = '0;
						bytes_left_d = bytes_left_q - LB'(1);
						phase_d      = PH_TX;
						ev           = i2ctam_pkg::EV_BYTE_TAKEN;
					end else begin
						ev      = i2ctam_pkg::EV_COMPLETE;
						phase_d = PH_IDLE;
					end
				end
			end
			PH_TX: begin
				if (fall) begin
					bit_count_d = bc_inc;
					if (bc_inc < 4'd8) begin
						shift_d     = {shift_q[6:0], 1'b0};
						sda_drive_d = shift_q[6];
					end else begin
						sda_drive_d = 1'b1;
						phase_d     = PH_MACK;
					end
				end
			end
			PH_MACK: begin
				if (rise) begin
					mack = !sda_s1;
					ev   = i2ctam_pkg::EV_MASTER_ACK;
				end else if (fall) begin
					if (bytes_left_q != '0) begin
						shift_d      = tx_byte_s1;
						sda_drive_d  = tx_byte_s1[7];
						bit_count_d  = '0;
						bytes_left_d = bytes_left_q - LB'(1);
						phase_d      = PH_TX;
						ev           = i2ctam_pkg::EV_BYTE_TAKEN;
					end else begin
						sda_drive_d = 1'b1;
						ev          = i2ctam_pkg::EV_COMPLETE;
						phase_d     = PH_IDLE;
					end
				end
			end
			default: begin
				// Idle, and any code that should never be held.
				phase_d     = PH_IDLE;
				sda_drive_d = 1'b1;
				if (prev_sda_q && !sda_s1 && scl_s1) begin
					phase_d = PH_START;
				end
			end
		endcase
		res_d.sda_release = sda_drive_d;
		res_d.event_res   = ev;
		res_d.master_ack  = mack;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q     <= '0;
			transmit_length_q <= '0;
		end else if (cfg.valid) begin
			case (i2ctam_pkg::reg_idx_t'(cfg.index))
				i2ctam_pkg::REG_OWN_ADDRESS: begin
					own_address_q <= cfg.data[i2ctam_pkg::ADDR_W-1:0];
				end
				i2ctam_pkg::REG_TRANSMIT_LENGTH: begin
					transmit_length_q <= cfg.data;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			scl_s1     <= samples.scl_level;
			sda_s1     <= samples.sda_level;
			tx_byte_s1 <= samples.tx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			bit_count_q   <= '0;
			shift_q       <= '0;
			bytes_left_q  <= '0;
			prev_scl_q    <= 1'b1;
			prev_sda_q    <= 1'b1;
			sda_drive_q   <= 1'b1;
			address_hit_q <= 1'b0;
		end else if (advance) begin
			phase_q       <= phase_d;
			bit_count_q   <= bit_count_d;
			shift_q       <= shift_d;
			bytes_left_q  <= bytes_left_d;
			prev_scl_q    <= scl_s1;
			prev_sda_q    <= sda_s1;
			sda_drive_q   <= sda_drive_d;
			address_hit_q <= address_hit_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_q] <= res_d;
		end
	end

endmodule

// ===== sv/i2ctam_checker.sv =====
`include "i2c_target_address_match_transmit_unit_macros.svh"

module i2ctam_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_ready,
	input logic               res_sda_release,
	input i2ctam_pkg::event_t res_event,
	input logic               res_master_ack
);

	// A result that is not taken stays on the port unchanged.
	`I2CTAM_ASSERT_NEXT(a_res_hold, res_valid && !res_ready,
		res_valid && $stable(res_sda_release) && $stable(res_event) && $stable(res_master_ack))

	// The acknowledge flag only carries meaning with a master-ack event.
	`I2CTAM_ASSERT_ALWAYS(a_mack_only_with_event,
		!(res_valid && res_master_ack) || (res_event == i2ctam_pkg::EV_MASTER_ACK))

	// A matched address pulls SDA low for the acknowledge slot.
	`I2CTAM_ASSERT_ALWAYS(a_match_drives_ack,
		!(res_valid && res_event == i2ctam_pkg::EV_MATCH) || !res_sda_release)

	// A mismatch, a sampled master ack and the end of a transaction leave SDA released.
	`I2CTAM_ASSERT_ALWAYS(a_release_on_events,
		!(res_valid && (res_event == i2ctam_pkg::EV_MISMATCH
			|| res_event == i2ctam_pkg::EV_MASTER_ACK
			|| res_event == i2ctam_pkg::EV_COMPLETE)) || res_sda_release)

endmodule

bind i2c_target_address_match_transmit_unit i2ctam_checker u_i2ctam_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (results.valid),
	.res_ready       (results.ready),
	.res_sda_release (results.sda_release),
	.res_event       (results.event_res),
	.res_master_ack  (results.master_ack)
);
